>>> src/qev_pkg.sv
// Shared types and constants for the x1 quadrature encoder counter with velocity.
// No dependencies.
`timescale 1ns / 1ps

package qev_pkg;

   localparam int unsigned PROD_W = 41;
   localparam int unsigned VEL_W  = 48;
   localparam int unsigned CNT_W  = 32;

   localparam logic CMD_EDGE   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [63:0] VEL_POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] VEL_NEG_LIM = 64'h0000_8000_0000_0000;

   typedef struct packed {
      logic        cmd;
      logic        b_level;
      logic [31:0] now_ms;
   } qev_req_type;

   typedef struct packed {
      logic signed [31:0] step_count;
      logic signed [47:0] velocity;
      logic               dt_zero;
   } qev_rsp_type;

endpackage

>>> src/qev_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, 32-bit divisor.
// Depends on nothing beyond its parameter.
`timescale 1ns / 1ps

module qev_div #(
   parameter int unsigned DVD_W = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [31:0]      divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int unsigned CW = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [31:0]      rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [32:0]      shifted;
   logic [32:0]      diff;
   logic             ge;

   assign shifted = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, divisor};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : shifted[31:0];
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

>>> src/quadrature_encoder_velocity_top.sv
// Top level of the x1 quadrature encoder counter with velocity measurement.
// Depends on qev_pkg and qev_div.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | qev_req_type (cmd, b_level, now_ms)
//   rsp     | out       | rsp_valid/rsp_ready  | qev_rsp_type (step_count, velocity, dt_zero)
//
// An edge request, or a sample that sees zero elapsed time, goes from idle straight to S_DONE.
// A velocity sample passes through S_MAG, S_MUL1, S_MUL2, S_LOAD, S_DIV, S_SAT and S_NEG;
// in S_DIV the bit-serial divider produces one quotient bit per cycle.
// Reset is synchronous and clears the count, the previous count and the previous time.
// A finished result waits in the output register; a new request is taken meanwhile.
`timescale 1ns / 1ps

module quadrature_encoder_velocity_top #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qev_pkg::qev_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qev_pkg::qev_rsp_type rsp_data
);

   import qev_pkg::*;

   localparam int unsigned DVD_W = PROD_W + FRAC_BITS;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MAG  = 9'b000000010,
      S_MUL1 = 9'b000000100,
      S_MUL2 = 9'b000001000,
      S_LOAD = 9'b000010000,
      S_DIV  = 9'b000100000,
      S_SAT  = 9'b001000000,
      S_NEG  = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  prev_count_ff, prev_count_in;
   logic [31:0]       prev_time_ff, prev_time_in;
   logic [CNT_W-1:0]  delta_ff, delta_in;
   logic [31:0]       dt_ff, dt_in;
   logic [31:0]       mag_ff, mag_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [VEL_W-1:0]  qsat_ff, qsat_in;
   logic [VEL_W-1:0]  vel_ff, vel_in;
   logic              dz_ff, dz_in;
   logic              rsp_valid_ff, rsp_valid_in;
   qev_rsp_type       rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              slot_free;
   logic              neg;
   logic [31:0]       dt_now;
   logic              div_start;
   logic              div_done;
   logic [DVD_W-1:0]  div_dividend;
   logic [DVD_W-1:0]  div_quotient;
   logic [63:0]       q_wide;
   logic [63:0]       q_limit;

   assign req_ready    = (state_ff == S_IDLE);
   assign accept       = req_valid && req_ready;
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign neg          = delta_ff[CNT_W-1];
   assign dt_now       = req_data.now_ms - prev_time_ff;
   assign div_start    = (state_ff == S_LOAD);
   assign div_dividend = DVD_W'(prod_ff) << FRAC_BITS;
   assign q_wide       = 64'(div_quotient);
   assign q_limit      = neg ? VEL_NEG_LIM : VEL_POS_MAX;

   qev_div #(
      .DVD_W(DVD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dt_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      prev_count_in = prev_count_ff;
      prev_time_in  = prev_time_ff;
      delta_in      = delta_ff;
      dt_in         = dt_ff;
      mag_in        = mag_ff;
      prod_in       = prod_ff;
      qsat_in       = qsat_ff;
      vel_in        = vel_ff;
      dz_in         = dz_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               vel_in = '0;
               dz_in  = 1'b0;
               if (req_data.cmd == CMD_EDGE) begin
                  count_in = req_data.b_level ? count_ff + CNT_W'(1) : count_ff - CNT_W'(1);
                  state_in = S_DONE;
               end else if (dt_now == '0) begin
                  dz_in    = 1'b1;
                  state_in = S_DONE;
               end else begin
                  dt_in         = dt_now;
                  delta_in      = count_ff - prev_count_ff;
                  prev_count_in = count_ff;
                  prev_time_in  = req_data.now_ms;
                  state_in      = S_MAG;
               end
            end
         end
         S_MAG: begin
            mag_in   = neg ? (32'd0 - delta_ff) : delta_ff;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            prod_in  = (PROD_W'(mag_ff) << 10) - (PROD_W'(mag_ff) << 4);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            prod_in  = prod_ff - (PROD_W'(mag_ff) << 3);
            state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            qsat_in  = (q_wide > q_limit) ? q_limit[VEL_W-1:0] : q_wide[VEL_W-1:0];
            state_in = S_NEG;
         end
         S_NEG: begin
            vel_in   = neg ? (VEL_W'(0) - qsat_ff) : qsat_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.step_count = $signed(count_ff);
               rsp_data_in.velocity   = $signed(vel_ff);
               rsp_data_in.dt_zero    = dz_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      delta_ff    <= delta_in;
      dt_ff       <= dt_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      qsat_ff     <= qsat_in;
      vel_ff      <= vel_in;
      dz_ff       <= dz_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         prev_count_ff <= '0;
         prev_time_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         prev_count_ff <= prev_count_in;
         prev_time_ff  <= prev_time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/qev_chk.sv
// Port-level checker for the encoder velocity block, bound to the top level.
// Depends on qev_pkg and quadrature_encoder_velocity_top.
`timescale 1ns / 1ps

module qev_chk (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input qev_pkg::qev_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input qev_pkg::qev_rsp_type rsp_data
);

   import qev_pkg::*;

   logic req_seen;
   assign req_seen = req_valid && req_ready && (req_data.cmd == CMD_SAMPLE);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_dt_zero_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dt_zero |-> rsp_data.velocity == '0)
      else $error("zero elapsed time with nonzero velocity");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_seen |=> !req_ready)
      else $error("request taken while a sample is still in work");

endmodule

bind quadrature_encoder_velocity_top qev_chk u_qev_chk (.*);

>>> dv/quadrature_encoder_velocity_top_test.sv
// Self-checking test of quadrature_encoder_velocity_top: directed and random edge and
// sample requests, with random idling on both channels. Depends on qev_pkg and the RTL.
`timescale 1ns / 1ps

module quadrature_encoder_velocity_top_test;
   import qev_pkg::*;

   localparam int unsigned FRAC = 8;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned RANDOM_ITEMS = 1400;

   class encoder_scoreboard;
      logic [31:0] count;
      logic [31:0] last_count;
      logic [31:0] last_time;
      qev_rsp_type expected_readings[$];
      int errors;

      function new();
         count = '0;
         last_count = '0;
         last_time = '0;
         errors = 0;
      endfunction

      function int outstanding();
         return expected_readings.size();
      endfunction

      // advance the encoder state and queue the reading it produces
      function void note_request(qev_req_type r);
         qev_rsp_type want;
         logic [31:0] span;
         logic [31:0] delta;
         logic [31:0] neg_delta;
         logic [63:0] mag;
         logic [63:0] quot;
         logic [63:0] wide;
         want = '0;
         if (r.cmd == CMD_EDGE) begin
            count = r.b_level ? count + 32'd1 : count - 32'd1;
         end else begin
            span = r.now_ms - last_time;
            if (span == 32'd0) begin
               want.dt_zero = 1'b1;
            end else begin
               delta = count - last_count;
               neg_delta = 32'd0 - delta;
               mag = delta[31] ? {32'd0, neg_delta} : {32'd0, delta};
               quot = ((mag * 64'd1000) << FRAC) / {32'd0, span};
               if (delta[31]) begin
                  if (quot > VEL_NEG_LIM) quot = VEL_NEG_LIM;
                  wide = 64'd0 - quot;
               end else begin
                  if (quot > VEL_POS_MAX) quot = VEL_POS_MAX;
                  wide = quot;
               end
               want.velocity = wide[47:0];
               last_count = count;
               last_time = r.now_ms;
            end
         end
         want.step_count = count;
         expected_readings.push_back(want);
      endfunction

      function void check_result(qev_rsp_type got);
         qev_rsp_type want;
         if (expected_readings.size() == 0) begin
            $error("unexpected response: step_count %0d velocity %0d dt_zero %0b",
                   got.step_count, got.velocity, got.dt_zero);
            errors++;
            return;
         end
         want = expected_readings.pop_front();
         if (got.step_count !== want.step_count) begin
            $error("step_count expected %0d actual %0d", want.step_count, got.step_count);
            errors++;
         end
         if (got.velocity !== want.velocity) begin
            $error("velocity expected %0d actual %0d", want.velocity, got.velocity);
            errors++;
         end
         if (got.dt_zero !== want.dt_zero) begin
            $error("dt_zero expected %0b actual %0b", want.dt_zero, got.dt_zero);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   qev_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   qev_rsp_type rsp_data;

   encoder_scoreboard sb = new();
   bit          idle_on;
   int unsigned stall_left;
   int unsigned cycle_count;
   logic [31:0] stamp;

   quadrature_encoder_velocity_top #(
      .FRAC_BITS(FRAC)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // hold off the response channel in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("quadrature_encoder_velocity_top verification failed");
         $finish;
      end
   end

   task automatic send_request(input qev_req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_edge(input logic b);
      qev_req_type r;
      r.cmd = CMD_EDGE;
      r.b_level = b;
      r.now_ms = $urandom();
      send_request(r);
   endtask

   task automatic send_sample(input logic [31:0] t);
      qev_req_type r;
      r.cmd = CMD_SAMPLE;
      r.b_level = 1'($urandom_range(0, 1));
      r.now_ms = t;
      if (t != stamp) stamp = t;
      send_request(r);
   endtask

   initial begin
      logic dir;
      int unsigned pick;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      stall_left = 0;
      cycle_count = 0;
      idle_on = 1'b1;
      stamp = '0;
      dir = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // zero elapsed time right after reset, then up and down counting
      send_sample(32'd0);
      repeat (3) send_edge(1'b1);
      send_edge(1'b0);
      send_sample(32'd1);
      send_sample(32'd1);
      repeat (5) send_edge(1'b0);
      // time wrap across the top of the millisecond counter
      send_sample(32'hFFFF_FFFF);
      send_sample(32'd3);
      repeat (2) send_edge(1'b0);
      // negative quotient truncated toward zero
      send_sample(32'd10);
      repeat (2) send_edge(1'b1);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h8000_0000);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_on = (i < RANDOM_ITEMS - 200) && ((i / 150) % 2 == 0);
         if (i == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.outstanding() != 0);
         end
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 40) == 0) dir = ~dir;
            send_edge(($urandom_range(0, 9) < 8) ? dir : ~dir);
         end else begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: begin
                  send_sample(stamp);
               end
               1: begin
                  send_sample($urandom());
               end
               2: begin
                  send_sample(stamp + 32'd1);
               end
               default: begin
                  send_sample(stamp + $urandom_range(1, 3000));
               end
            endcase
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (80) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("quadrature_encoder_velocity_top verification clean");
      end else begin
         $display("quadrature_encoder_velocity_top verification failed");
      end
      $finish;
   end

endmodule
